// ===== hw/rtl/character_range_expander_macros.svh =====
// Assertion macros used by the character range expander datapath.
`ifndef CHARACTER_RANGE_EXPANDER_MACROS_SVH
`define CHARACTER_RANGE_EXPANDER_MACROS_SVH

`ifndef NO_ASSERTIONS

// Check a property on every rising clk_i edge outside reset.
`define CRE_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Check that a condition never holds on a rising clk_i edge outside reset.
`define CRE_ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);

`else

`define CRE_ASSERT(lbl, prop, msg)
`define CRE_ASSERT_NEVER(lbl, cond, msg)

`endif

`endif

// ===== hw/rtl/cre_pkg.sv =====
// Types, constants and a helper function of the character range expander.
package cre_pkg;

  localparam logic [7:0] DashChar  = 8'h2D;
  localparam logic [7:0] LowerMin  = 8'h61;
  localparam logic [7:0] LowerMax  = 8'h7A;
  localparam logic [7:0] UpperMin  = 8'h41;
  localparam logic [7:0] UpperMax  = 8'h5A;
  localparam logic [7:0] DigitMin  = 8'h30;
  localparam logic [7:0] DigitMax  = 8'h39;

  typedef enum logic [1:0] {
    CLS_NONE  = 2'd0,
    CLS_LOWER = 2'd1,
    CLS_UPPER = 2'd2,
    CLS_DIGIT = 2'd3
  } char_class_e;

  typedef enum logic [2:0] {
    EMIT_NONE  = 3'd0,
    EMIT_IN    = 3'd1,
    EMIT_DASH  = 3'd2,
    EMIT_FIRST = 3'd3,
    EMIT_STEP  = 3'd4,
    EMIT_CUR   = 3'd5
  } emit_sel_e;

  typedef struct packed {
    logic      load;
    emit_sel_e sel;
    logic      last;
  } cre_cmd_t;

  typedef struct packed {
    logic slot_free;
    logic dash_pending;
    logic ends_match;
    logic range_nonempty;
    logic hold;
    logic step_done;
  } cre_status_t;

  function automatic char_class_e char_class(input logic [7:0] c);
    char_class_e cls;
    cls = CLS_NONE;
    if (c inside {[LowerMin:LowerMax]}) begin
      cls = CLS_LOWER;
    end else if (c inside {[UpperMin:UpperMax]}) begin
      cls = CLS_UPPER;
    end else if (c inside {[DigitMin:DigitMax]}) begin
      cls = CLS_DIGIT;
    end
    return cls;
  endfunction

endpackage

// ===== hw/rtl/cre_stream_if.sv =====
// Valid/ready stream interfaces for the input and result channels.
interface cre_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_char;
  logic       end_of_text;

  modport source (output valid, output in_char, output end_of_text, input ready);
  modport sink   (input valid, input in_char, input end_of_text, output ready);
endinterface

interface cre_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_char;
  logic       last_of_run;

  modport source (output valid, output out_char, output last_of_run, input ready);
  modport sink   (input valid, input out_char, input last_of_run, output ready);
endinterface

// ===== hw/rtl/cre_datapath.sv =====
// Datapath: neighbor state, range counter and output register.
`include "character_range_expander_macros.svh"

module cre_datapath (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic [7:0]          in_char_i,
  input  logic                end_of_text_i,
  input  logic                out_ready_i,
  output logic                out_valid_o,
  output logic [7:0]          out_char_o,
  output logic                out_last_o,
  input  cre_pkg::cre_cmd_t    cmd_i,
  output cre_pkg::cre_status_t status_o
);

  logic [7:0] prev_char_q, prev_char_d;
  logic       prev_valid_q, prev_valid_d;
  logic       pending_q, pending_d;
  logic [7:0] ctr_q, ctr_d;
  logic       up_q, up_d;
  logic [7:0] cur_q, cur_d;
  logic       out_valid_q, out_valid_d;
  logic [7:0] out_char_q, out_char_d;
  logic       out_last_q, out_last_d;

  cre_pkg::char_class_e in_cls, prev_cls;
  logic       up;
  logic [7:0] diff;
  logic [7:0] first;
  logic [7:0] step;
  logic       slot_free;
  logic       hold;

  always_comb begin
    in_cls    = cre_pkg::char_class(in_char_i);
    prev_cls  = cre_pkg::char_class(prev_char_q);
    up        = in_char_i > prev_char_q;
    diff      = up ? (in_char_i - prev_char_q) : (prev_char_q - in_char_i);
    first     = up ? (prev_char_q + 8'd1) : (prev_char_q - 8'd1);
    step      = up_q ? (ctr_q + 8'd1) : (ctr_q - 8'd1);
    slot_free = !out_valid_q || out_ready_i;
    hold      = (in_char_i == cre_pkg::DashChar) && prev_valid_q &&
                (prev_cls != cre_pkg::CLS_NONE) && !end_of_text_i;
  end

  assign status_o.slot_free      = slot_free;
  assign status_o.dash_pending   = pending_q;
  assign status_o.ends_match     = (prev_cls != cre_pkg::CLS_NONE) && (prev_cls == in_cls);
  assign status_o.range_nonempty = diff > 8'd1;
  assign status_o.hold           = hold;
  assign status_o.step_done      = step == cur_q;

  // Neighbor state follows the item at its transfer.
  always_comb begin
    prev_char_d  = prev_char_q;
    prev_valid_d = prev_valid_q;
    pending_d    = pending_q;
    if (cmd_i.load) begin
      if (pending_q) begin
        pending_d    = 1'b0;
        prev_char_d  = in_char_i;
        prev_valid_d = 1'b1;
      end else if (hold) begin
        pending_d    = 1'b1;
      end else begin
        prev_char_d  = in_char_i;
        prev_valid_d = 1'b1;
      end
      if (end_of_text_i) begin
        prev_char_d  = 8'd0;
        prev_valid_d = 1'b0;
        pending_d    = 1'b0;
      end
    end
  end

  always_comb begin
    ctr_d       = ctr_q;
    up_d        = up_q;
    cur_d       = cur_q;
    out_char_d  = out_char_q;
    out_last_d  = out_last_q;
    out_valid_d = out_valid_q && !out_ready_i;
    if (cmd_i.load) begin
      cur_d = in_char_i;
      up_d  = up;
      ctr_d = first;
    end
    if (cmd_i.sel != cre_pkg::EMIT_NONE) begin
      out_valid_d = 1'b1;
      out_last_d  = cmd_i.last;
    end
    case (cmd_i.sel)
      cre_pkg::EMIT_IN:    out_char_d = in_char_i;
      cre_pkg::EMIT_DASH:  out_char_d = cre_pkg::DashChar;
      cre_pkg::EMIT_FIRST: out_char_d = first;
      cre_pkg::EMIT_STEP: begin
        out_char_d = step;
        ctr_d      = step;
      end
      cre_pkg::EMIT_CUR:   out_char_d = cur_q;
      default:             out_char_d = out_char_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_char_q  <= 8'd0;
      prev_valid_q <= 1'b0;
      pending_q    <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      prev_char_q  <= prev_char_d;
      prev_valid_q <= prev_valid_d;
      pending_q    <= pending_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ctr_q      <= ctr_d;
    up_q       <= up_d;
    cur_q      <= cur_d;
    out_char_q <= out_char_d;
    out_last_q <= out_last_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_char_o  = out_char_q;
  assign out_last_o  = out_last_q;

  `CRE_ASSERT_NEVER(a_emit_into_full, (cmd_i.sel != cre_pkg::EMIT_NONE) && !slot_free, "result register overwritten")
  `CRE_ASSERT(a_pending_has_left, pending_q |-> prev_valid_q, "held dash without left neighbor")
  `CRE_ASSERT(a_pending_left_class, pending_q |-> (prev_cls != cre_pkg::CLS_NONE), "held dash after unclassed character")
  `CRE_ASSERT(a_step_in_range, (cmd_i.sel == cre_pkg::EMIT_STEP) |-> (step != cur_q), "range step past right end")

endmodule

// ===== hw/rtl/cre_ctrl.sv =====
// Controller: sequences the results of one input item.
module cre_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  cre_pkg::cre_status_t status_i,
  output cre_pkg::cre_cmd_t    cmd_o
);

  typedef enum logic [2:0] {
    S_IDLE  = 3'b001,
    S_RANGE = 3'b010,
    S_CHAR  = 3'b100
  } state_e;

  state_e state_q, state_d;
  logic   accept;

  assign in_ready_o = (state_q == S_IDLE) && status_i.slot_free;
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    state_d    = state_q;
    cmd_o.load = accept;
    cmd_o.sel  = cre_pkg::EMIT_NONE;
    cmd_o.last = 1'b0;
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          if (status_i.dash_pending) begin
            if (status_i.ends_match && status_i.range_nonempty) begin
              cmd_o.sel = cre_pkg::EMIT_FIRST;
              state_d   = S_RANGE;
            end else if (status_i.ends_match) begin
              cmd_o.sel  = cre_pkg::EMIT_IN;
              cmd_o.last = 1'b1;
            end else begin
              cmd_o.sel = cre_pkg::EMIT_DASH;
              state_d   = S_CHAR;
            end
          end else if (!status_i.hold) begin
            cmd_o.sel  = cre_pkg::EMIT_IN;
            cmd_o.last = 1'b1;
          end
        end
      end
      S_RANGE: begin
        if (status_i.slot_free) begin
          if (status_i.step_done) begin
            cmd_o.sel  = cre_pkg::EMIT_CUR;
            cmd_o.last = 1'b1;
            state_d    = S_IDLE;
          end else begin
            cmd_o.sel = cre_pkg::EMIT_STEP;
          end
        end
      end
      S_CHAR: begin
        if (status_i.slot_free) begin
          cmd_o.sel  = cre_pkg::EMIT_CUR;
          cmd_o.last = 1'b1;
          state_d    = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ===== hw/rtl/character_range_expander.sv =====
// Character range expander: one character in, its expansion out, one character per cycle while out_o is ready.
//
// Each input transfer carries one character. A character that is simply copied gives one
// result; a dash that may start a range is held until the next character, with no result;
// the character after a held dash gives the range characters strictly between the two
// ends plus the right end, or a literal dash plus the character, so at most 25 results.
// The single result register, loaded with one character per cycle while out_o is ready,
// sets the rate. A new character is taken no earlier than the transfer of the previous
// item's final result, at the earliest in the same cycle as that transfer.
module character_range_expander (
  input  logic      clk_i,
  input  logic      rst_ni,
  cre_in_if.sink    in_i,
  cre_out_if.source out_o
);

  cre_pkg::cre_cmd_t    cmd;
  cre_pkg::cre_status_t status;

  cre_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_i.ready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  cre_datapath u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_char_i     (in_i.in_char),
    .end_of_text_i (in_i.end_of_text),
    .out_ready_i   (out_o.ready),
    .out_valid_o   (out_o.valid),
    .out_char_o    (out_o.out_char),
    .out_last_o    (out_o.last_of_run),
    .cmd_i         (cmd),
    .status_o      (status)
  );

endmodule

// ===== sim/character_range_expander_checker.sv =====
// Checker for the character range expander: predicts the expanded stream and compares results.
module character_range_expander_checker (
  input  logic clk_i,
  input  logic rst_ni,
  cre_in_if    in_i,
  cre_out_if   out_i,
  output int   errors_o,
  output int   outstanding_o
);

  typedef struct packed {
    logic [7:0] ch;
    logic       last;
  } out_char_t;

  out_char_t  expansion_q[$];
  logic [7:0] prev_char;
  logic       prev_valid;
  logic       dash_held;

  function automatic cre_pkg::char_class_e class_of(input logic [7:0] c);
    if (c >= cre_pkg::LowerMin && c <= cre_pkg::LowerMax) return cre_pkg::CLS_LOWER;
    if (c >= cre_pkg::UpperMin && c <= cre_pkg::UpperMax) return cre_pkg::CLS_UPPER;
    if (c >= cre_pkg::DigitMin && c <= cre_pkg::DigitMax) return cre_pkg::CLS_DIGIT;
    return cre_pkg::CLS_NONE;
  endfunction

  task automatic expand_char(input logic [7:0] c, input logic eot);
    cre_pkg::char_class_e k;
    logic [7:0]  left;
    logic        left_valid;
    int          j;
    int          n;
    n = 0;
    if (dash_held) begin
      k = class_of(prev_char);
      if (k != cre_pkg::CLS_NONE && k == class_of(c)) begin
        if (prev_char < c) begin
          for (j = int'(prev_char) + 1; j < int'(c); j++) begin
            expansion_q.push_back('{8'(j), 1'b0});
            n++;
          end
        end else if (prev_char > c) begin
          for (j = int'(prev_char) - 1; j > int'(c); j--) begin
            expansion_q.push_back('{8'(j), 1'b0});
            n++;
          end
        end
      end else begin
        expansion_q.push_back('{cre_pkg::DashChar, 1'b0});
        n++;
      end
      dash_held = 1'b0;
      left = cre_pkg::DashChar;
      left_valid = 1'b1;
    end else begin
      left = prev_char;
      left_valid = prev_valid;
    end
    if (c == cre_pkg::DashChar && left_valid && class_of(left) != cre_pkg::CLS_NONE && !eot)
    begin
      dash_held = 1'b1;
      prev_char = left;
      prev_valid = 1'b1;
    end else begin
      expansion_q.push_back('{c, 1'b0});
      n++;
      prev_char = c;
      prev_valid = 1'b1;
    end
    if (eot) begin
      prev_char = 8'h00;
      prev_valid = 1'b0;
      dash_held = 1'b0;
    end
    if (n > 0) expansion_q[expansion_q.size() - 1].last = 1'b1;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    out_char_t want;
    if (!rst_ni) begin
      prev_char = 8'h00;
      prev_valid = 1'b0;
      dash_held = 1'b0;
      expansion_q.delete();
      errors_o <= 0;
      outstanding_o <= 0;
    end else begin
      if (in_i.valid && in_i.ready) expand_char(in_i.in_char, in_i.end_of_text);
      if (out_i.valid && out_i.ready) begin
        if (expansion_q.size() == 0) begin
          $display("%0t: unexpected transfer, expected none, got out_char %02h last_of_run %0b",
                   $time, out_i.out_char, out_i.last_of_run);
          errors_o <= errors_o + 1;
        end else begin
          want = expansion_q.pop_front();
          if (out_i.out_char !== want.ch || out_i.last_of_run !== want.last) begin
            $display("%0t: out_char expected %02h got %02h, last_of_run expected %0b got %0b",
                     $time, want.ch, out_i.out_char, want.last, out_i.last_of_run);
            errors_o <= errors_o + 1;
          end
        end
      end
      outstanding_o <= expansion_q.size();
    end
  end

endmodule

// ===== sim/character_range_expander_test.sv =====
// Testbench top for the character range expander: clock, reset, stimulus and verdict.
module character_range_expander_test;

  localparam int LongHold = 300;

  localparam logic [8:0] Directed [25] = '{
    {1'b0, cre_pkg::DashChar}, {1'b0, "a"}, {1'b0, cre_pkg::DashChar}, {1'b0, "z"},
    {1'b0, cre_pkg::DashChar}, {1'b0, "a"}, {1'b0, "5"}, {1'b0, cre_pkg::DashChar},
    {1'b0, "5"}, {1'b0, "Q"}, {1'b0, cre_pkg::DashChar}, {1'b0, "B"}, {1'b0, "c"},
    {1'b0, cre_pkg::DashChar}, {1'b0, "D"}, {1'b0, cre_pkg::DashChar},
    {1'b0, cre_pkg::DashChar}, {1'b0, "x"}, {1'b1, cre_pkg::DashChar}, {1'b0, "9"},
    {1'b0, cre_pkg::DashChar}, {1'b1, "0"}, {1'b0, 8'hFF}, {1'b0, 8'h00}, {1'b1, 8'h80}
  };

  logic clk_i = 1'b0;
  logic rst_ni;
  int   errors;
  int   outstanding;
  int   chars_sent = 0;
  bit   tx_idle_on = 1'b1;
  bit   rx_idle_on = 1'b1;
  bit   rx_hold_req = 1'b0;

  cre_in_if  in_if ();
  cre_out_if out_if ();

  character_range_expander i_dut (
    .clk_i,
    .rst_ni,
    .in_i  (in_if),
    .out_o (out_if)
  );

  character_range_expander_checker i_checker (
    .clk_i,
    .rst_ni,
    .in_i          (in_if),
    .out_i         (out_if),
    .errors_o      (errors),
    .outstanding_o (outstanding)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  initial begin
    #20_000_000;
    $display("CHECK FAILED");
    $finish;
  end

  initial begin
    forever begin
      if (rx_hold_req) begin
        out_if.ready <= 1'b0;
        repeat (LongHold) @(posedge clk_i);
        rx_hold_req = 1'b0;
      end else if (rx_idle_on && $urandom_range(0, 9) == 0) begin
        out_if.ready <= 1'b0;
        repeat ($urandom_range(1, 18)) @(posedge clk_i);
      end else begin
        out_if.ready <= 1'b1;
        @(posedge clk_i);
      end
    end
  end

  function automatic logic [7:0] pick_char(input cre_pkg::char_class_e k);
    case (k)
      cre_pkg::CLS_LOWER: return cre_pkg::LowerMin + 8'($urandom_range(0, 25));
      cre_pkg::CLS_UPPER: return cre_pkg::UpperMin + 8'($urandom_range(0, 25));
      cre_pkg::CLS_DIGIT: return cre_pkg::DigitMin + 8'($urandom_range(0, 9));
      default: return ($urandom_range(0, 3) == 0) ? cre_pkg::DashChar
                                                  : 8'($urandom_range(0, 255));
    endcase
  endfunction

  task automatic send_char(input logic [7:0] c, input logic eot);
    int gap;
    gap = (tx_idle_on && $urandom_range(0, 5) == 0) ? $urandom_range(1, 18) : 0;
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_if.valid <= 1'b1;
    in_if.in_char <= c;
    in_if.end_of_text <= eot;
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
    chars_sent++;
  endtask

  task automatic send_text(input int count);
    int                   stop;
    cre_pkg::char_class_e k;
    cre_pkg::char_class_e k_other;
    stop = chars_sent + count;
    while (chars_sent < stop) begin
      k = cre_pkg::char_class_e'($urandom_range(1, 3));
      k_other = cre_pkg::char_class_e'((int'(k) % 3) + 1);
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4, 5: begin
          send_char(pick_char(k), 1'b0);
          repeat ($urandom_range(1, 2)) begin
            send_char(cre_pkg::DashChar, 1'b0);
            send_char(pick_char(k), $urandom_range(0, 15) == 0);
          end
        end
        6, 7: send_char(pick_char(cre_pkg::char_class_e'($urandom_range(0, 3))),
                        $urandom_range(0, 20) == 0);
        8: send_char(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
        default: begin
          send_char(pick_char(k), 1'b0);
          send_char(cre_pkg::DashChar, 1'($urandom_range(0, 1)));
          send_char(pick_char(k_other), 1'b0);
        end
      endcase
    end
  endtask

  task automatic drain_results();
    in_if.valid <= 1'b0;
    @(posedge clk_i);
    while (outstanding != 0) @(posedge clk_i);
  endtask

  initial begin
    rst_ni <= 1'b0;
    in_if.valid <= 1'b0;
    in_if.in_char <= 8'h00;
    in_if.end_of_text <= 1'b0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (Directed[i]) send_char(Directed[i][7:0], Directed[i][8]);

    send_text(40);
    rx_hold_req = 1'b1;
    send_text(80);
    drain_results();
    send_text(85);

    tx_idle_on = 1'b0;
    rx_idle_on = 1'b0;
    send_text(100);

    drain_results();
    repeat (40) @(posedge clk_i);
    if (errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
